@@ design/windowed_genotype_correlation_defines.svh @@
// Assertion macros used by the checker file.
`ifndef WINDOWED_GENOTYPE_CORRELATION_DEFINES_SVH
`define WINDOWED_GENOTYPE_CORRELATION_DEFINES_SVH

`define WGC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define WGC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/wgc_pkg.sv @@
package wgc_pkg;

  localparam int MaxSamples   = 256;
  localparam int MaxVariants  = 1024;
  localparam int MaxLookback  = 63;
  localparam int RFracBits    = 14;
  localparam int PaddrW       = 4;
  localparam int VarW         = 10;
  localparam int SmpW         = 8;
  localparam int KeptW        = 6;

  localparam logic [1:0] GenoMissing = 2'd3;

  typedef enum logic [1:0] {
    ModeGeno     = 2'd0,
    ModePosition = 2'd1,
    ModeThresh   = 2'd2,
    ModeCompute  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    CfgSampleCount  = 2'd0,
    CfgVariantCount = 2'd1,
    CfgWindowSize   = 2'd2,
    CfgIncludeSelf  = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]      mode;
    logic [VarW-1:0] variant_index;
    logic [SmpW-1:0] sample_index;
    logic [1:0]      genotype;
    logic [31:0]     position;
    logic [14:0]     threshold;
  } in_item_t;

  typedef struct packed {
    logic [VarW-1:0]    neighbor_index;
    logic signed [15:0] correlation;
    logic               undefined;
    logic [8:0]         pair_count;
    logic               entry_valid;
    logic               truncated;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic [VarW-1:0]    index;
    logic signed [15:0] correlation;
    logic               undefined;
    logic [8:0]         pair_count;
  } kept_t;

  typedef struct packed {
    logic        start;
    logic [36:0] a2;
    logic [36:0] d;
  } ds_req_t;

  typedef struct packed {
    logic        done;
    logic [14:0] mag;
  } ds_rsp_t;

endpackage

@@ design/wgc_in_if.sv @@
interface wgc_in_if import wgc_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/wgc_out_if.sv @@
interface wgc_out_if import wgc_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ design/wgc_root.sv @@
// Rounded magnitude of a / sqrt(d): a restoring divide of a^2 * 2^30 by d, then a
// restoring square root, one quotient bit or one root bit per cycle.
module wgc_root import wgc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  ds_req_t req_i,
  output ds_rsp_t rsp_o
);

  typedef enum logic [3:0] {
    DS_IDLE = 4'b0001,
    DS_DIV  = 4'b0010,
    DS_SQRT = 4'b0100,
    DS_DONE = 4'b1000
  } ds_state_e;

  ds_state_e   state_q, state_d;
  logic [4:0]  cnt_q;
  logic [36:0] r_q, d_q;
  logic        b0_q;
  logic [30:0] quo_q;
  logic [31:0] t_q;
  logic [17:0] rem_q;
  logic [15:0] root_q;

  logic [37:0] div_s;
  logic        div_ge;
  logic [19:0] sq_s, sq_trial;
  logic        sq_ge;

  assign div_s    = {r_q, (cnt_q == 5'd0) ? b0_q : 1'b0};
  assign div_ge   = div_s >= {1'b0, d_q};
  assign sq_s     = {rem_q, t_q[31:30]};
  assign sq_trial = {2'b00, root_q, 2'b01};
  assign sq_ge    = sq_s >= sq_trial;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      DS_IDLE: if (req_i.start) state_d = DS_DIV;
      DS_DIV:  if (cnt_q == 5'd30) state_d = DS_SQRT;
      DS_SQRT: if (cnt_q == 5'd15) state_d = DS_DONE;
      DS_DONE: state_d = DS_IDLE;
      default: state_d = DS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= DS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      DS_IDLE: begin
        if (req_i.start) begin
          r_q   <= {1'b0, req_i.a2[36:1]};
          b0_q  <= req_i.a2[0];
          d_q   <= req_i.d;
          quo_q <= '0;
          cnt_q <= '0;
        end
      end
      DS_DIV: begin
        r_q   <= div_ge ? 37'(div_s - {1'b0, d_q}) : div_s[36:0];
        quo_q <= {quo_q[29:0], div_ge};
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd30) begin
          t_q    <= {1'b0, quo_q[29:0], div_ge};
          rem_q  <= '0;
          root_q <= '0;
          cnt_q  <= '0;
        end
      end
      DS_SQRT: begin
        rem_q  <= 18'(sq_ge ? sq_s - sq_trial : sq_s);
        root_q <= {root_q[14:0], sq_ge};
        t_q    <= {t_q[29:0], 2'b00};
        cnt_q  <= cnt_q + 5'd1;
      end
      default: ;
    endcase
  end

  assign rsp_o.done = (state_q == DS_DONE);
  assign rsp_o.mag  = 15'((17'(root_q) + 17'd1) >> 1);

endmodule

@@ design/windowed_genotype_correlation.sv @@
// Channel  Dir  Handshake      Payload
// in_i     in   valid/ready    mode, variant_index, sample_index, genotype, position, threshold
// out_o    out  valid/ready    neighbor_index, correlation, undefined, pair_count, flags
// apb      in   psel/penable   sample_count, variant_count, window_size, include_self
//
// A load is written to its store when it is accepted. A compute reads the n samples of the
// own variant, then for each compared neighbor reads n samples through the two genotype read
// ports, then runs the shared multiplier and the bit serial divide and root (the divide and
// root are skipped when undefined), then sends the results while the output side is ready.
// Reset sets control and configuration only; the stores hold nothing until written.
// The block takes no item while a result waits in the output register.
module windowed_genotype_correlation import wgc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  wgc_in_if.sink            in_i,
  wgc_out_if.source         out_o
);

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_PC     = 13'b0000000000010,
    S_PC2    = 13'b0000000000100,
    S_SELF   = 13'b0000000001000,
    S_WJ     = 13'b0000000010000,
    S_WT     = 13'b0000000100000,
    S_ACC    = 13'b0000001000000,
    S_MUL    = 13'b0000010000000,
    S_RSTART = 13'b0000100000000,
    S_ROOT   = 13'b0001000000000,
    S_KEEP   = 13'b0010000000000,
    S_EMIT   = 13'b0100000000000,
    S_ELOAD  = 13'b1000000000000
  } state_e;

  state_e state_q, state_d;

  logic [8:0]  sample_count_q;
  logic [10:0] variant_count_q;
  logic [31:0] window_size_q;
  logic        include_self_q;

  logic [1:0]  geno_mem [MaxVariants*MaxSamples];
  logic [31:0] pos_mem [MaxVariants];
  logic [14:0] thr_mem [MaxSamples];
  kept_t       kept_mem [MaxLookback+1];

  logic [1:0]  gx_q, gy_q;
  logic [31:0] pos_rd_q, posc_q;
  logic [14:0] thr_rd_q;
  kept_t       kept_rd_q;

  logic [VarW-1:0]  c_q, j_q;
  logic [8:0]       i_q, self_cnt_q;
  logic             rd_vld_q;
  logic [KeptW-1:0] steps_q, nkept_q, e_q;
  logic             trunc_q;
  logic [8:0]       k_q;
  logic [9:0]       sx_q, sy_q;
  logic [10:0]      sxx_q, syy_q, sxy_q;
  logic [3:0]       mstep_q;
  logic [37:0]      p_q;
  logic [18:0]      t1_q, dx_q, dy_q;
  logic signed [19:0] num_q;
  logic [36:0]      a2_q, d_q;

  logic        out_vld_q, out_load;
  out_item_t   out_q, out_d;

  logic        accept, cfg_we, in_win, undef, keep, acc_ok, fetch_done;
  logic [8:0]  n_eff;
  logic [10:0] m_eff;
  logic [18:0] opa, opb, a_abs;
  logic [3:0]  xx, yy, xy;
  logic signed [15:0] corr;
  logic [VarW-1:0] pos_raddr;
  ds_req_t     ds_req;
  ds_rsp_t     ds_rsp;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;

  always_comb begin
    unique case (cfg_idx_e'(paddr[3:2]))
      CfgSampleCount:  prdata = {23'd0, sample_count_q};
      CfgVariantCount: prdata = {21'd0, variant_count_q};
      CfgWindowSize:   prdata = window_size_q;
      CfgIncludeSelf:  prdata = {31'd0, include_self_q};
      default:         prdata = '0;
    endcase
  end

  assign n_eff = (sample_count_q > 9'(MaxSamples)) ? 9'(MaxSamples) : sample_count_q;
  assign m_eff = (variant_count_q > 11'(MaxVariants)) ? 11'(MaxVariants) : variant_count_q;

  assign in_i.ready = (state_q == S_IDLE) && !out_vld_q;
  assign accept     = in_i.valid && in_i.ready;

  assign in_win     = ({1'b0, pos_rd_q} + {1'b0, window_size_q}) >= {1'b0, posc_q};
  assign fetch_done = (i_q == n_eff) && !rd_vld_q;
  assign acc_ok     = (gx_q != GenoMissing) && (gy_q != GenoMissing);
  assign xx         = 4'(gx_q) * 4'(gx_q);
  assign yy         = 4'(gy_q) * 4'(gy_q);
  assign xy         = 4'(gx_q) * 4'(gy_q);
  assign a_abs      = num_q[19] ? 19'(-num_q) : num_q[18:0];
  assign undef      = (dx_q == '0) || (dy_q == '0);
  assign corr       = num_q[19] ? -16'(ds_rsp.mag) : 16'(ds_rsp.mag);
  assign keep       = undef || (ds_rsp.mag > thr_rd_q);
  assign pos_raddr  = (state_q == S_WJ) ? j_q : c_q;

  always_comb begin
    opa = '0;
    opb = '0;
    case (mstep_q)
      4'd0: begin opa = 19'(k_q);  opb = 19'(sxy_q); end
      4'd1: begin opa = 19'(sx_q); opb = 19'(sy_q);  end
      4'd2: begin opa = 19'(k_q);  opb = 19'(sxx_q); end
      4'd3: begin opa = 19'(sx_q); opb = 19'(sx_q);  end
      4'd4: begin opa = 19'(k_q);  opb = 19'(syy_q); end
      4'd5: begin opa = 19'(sy_q); opb = 19'(sy_q);  end
      4'd6: begin opa = a_abs;     opb = a_abs;      end
      4'd7: begin opa = dx_q;      opb = dy_q;       end
      default: ;
    endcase
  end

  assign ds_req.start = (state_q == S_RSTART);
  assign ds_req.a2    = a2_q;
  assign ds_req.d     = d_q;

  wgc_root u_root (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (ds_req),
    .rsp_o (ds_rsp)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (mode_e'(in_i.data.mode) == ModeCompute) &&
            ({1'b0, in_i.data.variant_index} < m_eff)) begin
          state_d = S_PC;
        end
      end
      S_PC:     state_d = S_PC2;
      S_PC2:    state_d = S_SELF;
      S_SELF:   if (fetch_done) state_d = S_WJ;
      S_WJ:     state_d = ({4'd0, steps_q} >= c_q) ? S_EMIT : S_WT;
      S_WT: begin
        if (!in_win || (steps_q == KeptW'(MaxLookback))) state_d = S_EMIT;
        else state_d = S_ACC;
      end
      S_ACC:    if (fetch_done) state_d = S_MUL;
      S_MUL: begin
        if (mstep_q == 4'd8) state_d = undef ? S_KEEP : S_RSTART;
      end
      S_RSTART: state_d = S_ROOT;
      S_ROOT:   if (ds_rsp.done) state_d = S_KEEP;
      S_KEEP:   state_d = S_WJ;
      S_EMIT: begin
        if (!out_vld_q) state_d = (e_q != '0) ? S_ELOAD : S_IDLE;
      end
      S_ELOAD: begin
        if ((e_q == KeptW'(1)) && !include_self_q) state_d = S_IDLE;
        else state_d = S_EMIT;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_load = 1'b0;
    out_d    = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (mode_e'(in_i.data.mode) == ModeCompute) &&
            ({1'b0, in_i.data.variant_index} >= m_eff)) begin
          out_load             = 1'b1;
          out_d.neighbor_index = in_i.data.variant_index;
          out_d.last           = 1'b1;
        end
      end
      S_EMIT: begin
        if (!out_vld_q && (e_q == '0)) begin
          if (include_self_q) begin
            out_load             = 1'b1;
            out_d.neighbor_index = c_q;
            out_d.correlation    = 16'(1 << RFracBits);
            out_d.pair_count     = self_cnt_q;
            out_d.entry_valid    = 1'b1;
            out_d.truncated      = trunc_q;
            out_d.last           = 1'b1;
          end else if (nkept_q == '0) begin
            out_load             = 1'b1;
            out_d.neighbor_index = c_q;
            out_d.truncated      = trunc_q;
            out_d.last           = 1'b1;
          end
        end
      end
      S_ELOAD: begin
        out_load             = 1'b1;
        out_d.neighbor_index = kept_rd_q.index;
        out_d.correlation    = kept_rd_q.correlation;
        out_d.undefined      = kept_rd_q.undefined;
        out_d.pair_count     = kept_rd_q.pair_count;
        out_d.entry_valid    = 1'b1;
        out_d.truncated      = trunc_q;
        out_d.last           = (e_q == KeptW'(1)) && !include_self_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= S_IDLE;
      out_vld_q       <= 1'b0;
      rd_vld_q        <= 1'b0;
      sample_count_q  <= 9'd256;
      variant_count_q <= 11'd1024;
      window_size_q   <= '0;
      include_self_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= ((state_q == S_SELF) || (state_q == S_ACC)) && (i_q < n_eff);
      if (out_load) out_vld_q <= 1'b1;
      else if (out_o.ready) out_vld_q <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_idx_e'(paddr[3:2]))
          CfgSampleCount:  sample_count_q  <= pwdata[8:0];
          CfgVariantCount: variant_count_q <= pwdata[10:0];
          CfgWindowSize:   window_size_q   <= pwdata;
          CfgIncludeSelf:  include_self_q  <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) out_q <= out_d;
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i) begin
    if (accept && (mode_e'(in_i.data.mode) == ModeGeno)) begin
      geno_mem[{in_i.data.variant_index, in_i.data.sample_index}] <= in_i.data.genotype;
    end
    gx_q <= geno_mem[{c_q, i_q[SmpW-1:0]}];
    gy_q <= geno_mem[{j_q, i_q[SmpW-1:0]}];
  end

  always_ff @(posedge clk_i) begin
    if (accept && (mode_e'(in_i.data.mode) == ModePosition)) begin
      pos_mem[in_i.data.variant_index] <= in_i.data.position;
    end
    pos_rd_q <= pos_mem[pos_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (accept && (mode_e'(in_i.data.mode) == ModeThresh)) begin
      thr_mem[in_i.data.sample_index] <= in_i.data.threshold;
    end
    thr_rd_q <= thr_mem[8'(k_q - 9'd1)];
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_KEEP) && keep) begin
      kept_mem[nkept_q] <= '{index: j_q, correlation: undef ? 16'sd0 : corr,
                             undefined: undef, pair_count: k_q};
    end
    kept_rd_q <= kept_mem[KeptW'(e_q - KeptW'(1))];
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        c_q        <= in_i.data.variant_index;
        j_q        <= in_i.data.variant_index - VarW'(1);
        self_cnt_q <= '0;
        nkept_q    <= '0;
        steps_q    <= '0;
        trunc_q    <= 1'b0;
        i_q        <= '0;
      end
      S_PC2: posc_q <= pos_rd_q;
      S_SELF: begin
        if (i_q < n_eff) i_q <= i_q + 9'd1;
        if (rd_vld_q && (gx_q != GenoMissing)) self_cnt_q <= self_cnt_q + 9'd1;
      end
      S_WJ: e_q <= nkept_q;
      S_WT: begin
        if (in_win && (steps_q == KeptW'(MaxLookback))) trunc_q <= 1'b1;
        i_q     <= '0;
        mstep_q <= '0;
        k_q     <= '0;
        sx_q    <= '0;
        sy_q    <= '0;
        sxx_q   <= '0;
        syy_q   <= '0;
        sxy_q   <= '0;
      end
      S_ACC: begin
        if (i_q < n_eff) i_q <= i_q + 9'd1;
        if (rd_vld_q && acc_ok) begin
          k_q   <= k_q + 9'd1;
          sx_q  <= sx_q + 10'(gx_q);
          sy_q  <= sy_q + 10'(gy_q);
          sxx_q <= sxx_q + 11'(xx);
          syy_q <= syy_q + 11'(yy);
          sxy_q <= sxy_q + 11'(xy);
        end
      end
      S_MUL: begin
        p_q     <= opa * opb;
        mstep_q <= mstep_q + 4'd1;
        case (mstep_q)
          4'd1, 4'd3, 4'd5: t1_q <= p_q[18:0];
          4'd2: num_q <= $signed({1'b0, t1_q}) - $signed({1'b0, p_q[18:0]});
          4'd4: dx_q  <= t1_q - p_q[18:0];
          4'd6: dy_q  <= t1_q - p_q[18:0];
          4'd7: a2_q  <= p_q[36:0];
          4'd8: d_q   <= p_q[36:0];
          default: ;
        endcase
      end
      S_KEEP: begin
        if (keep) nkept_q <= nkept_q + KeptW'(1);
        steps_q <= steps_q + KeptW'(1);
        j_q     <= j_q - VarW'(1);
        e_q     <= (keep ? nkept_q + KeptW'(1) : nkept_q);
      end
      S_ELOAD: e_q <= e_q - KeptW'(1);
      default: ;
    endcase
  end

endmodule

@@ design/wgc_checker.sv @@
`include "windowed_genotype_correlation_defines.svh"

module wgc_checker import wgc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_i,
  input logic      out_valid_i,
  input logic      out_ready_i,
  input out_item_t out_data_i
);

  `WGC_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(out_data_i), "result dropped or changed while stalled")
  `WGC_ASSERT_IMPL(a_in_blocked, in_ready_i && in_valid_i, !out_valid_i, "input taken while a result waits")
  `WGC_ASSERT_IMPL(a_mid_valid, out_valid_i && !out_data_i.last, out_data_i.entry_valid, "non-final result without an entry")
  `WGC_ASSERT_IMPL(a_closing_zero, out_valid_i && !out_data_i.entry_valid, out_data_i.last && out_data_i.correlation == 16'sd0 && out_data_i.pair_count == 9'd0, "closing result carries data")
  `WGC_ASSERT_IMPL(a_undef_zero, out_valid_i && out_data_i.undefined, out_data_i.correlation == 16'sd0, "undefined result with nonzero correlation")

endmodule

bind windowed_genotype_correlation wgc_checker u_wgc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_data_i (out_o.data)
);
